// File: hdl/url_psd_pkg.sv
// URL path cleaner: shared constants, result word type and hex digit decode.
// No dependencies.
`default_nettype none

package url_psd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxRes = 3;

  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] ChSlash   = 8'h2F;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;
  localparam logic [ByteW-1:0] ChUpperA  = 8'h41;
  localparam logic [ByteW-1:0] ChUpperF  = 8'h46;
  localparam logic [ByteW-1:0] ChLowerA  = 8'h61;
  localparam logic [ByteW-1:0] ChLowerF  = 8'h66;

  // escape phase codes
  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhPct   = 2'd1;
  localparam logic [1:0] PhDigit = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] out_char;
    logic             has_char;
    logic             path_done;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    logic [ByteW-1:0] d;
    h.ok  = 1'b0;
    h.val = 4'd0;
    d     = '0;
    if (c >= ChZero && c <= ChNine) begin
      d     = c - ChZero;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      d     = c - ChUpperA + 8'd10;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      d     = c - ChLowerA + 8'd10;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: hdl/url_psd_if.sv
// URL path cleaner: valid/ready channel interfaces for path bytes and result words.
// Depends on url_psd_pkg.
`default_nettype none

interface url_psd_in_if;
  import url_psd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] path_byte;
  logic             is_final;
  modport source (output valid, output path_byte, output is_final, input ready);
  modport sink   (input valid, input path_byte, input is_final, output ready);
endinterface

interface url_psd_out_if;
  import url_psd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_char;
  logic             has_char;
  logic             path_done;
  modport source (output valid, output out_char, output has_char, output path_done,
                  input ready);
  modport sink   (input valid, input out_char, input has_char, input path_done,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/url_path_slash_collapse_percent_decode_core.sv
// URL path cleaner top level: slash collapsing and percent decoding, one byte per word.
// Depends on url_psd_pkg and the channel interfaces in url_psd_if.sv.
//
// A path byte is decoded in the cycle it is accepted and its result words (zero to three)
// land in a four-entry output queue, drained one word per cycle while the receiver is
// ready. A byte is taken whenever the queue holds at most one word, so a stream giving
// one word per byte runs at one byte per cycle when the output does not stall; a byte
// with more words holds off input until the queue drains to one word. The last path byte
// flushes held escape characters; a bare end marker is sent if it yields nothing else.
`default_nettype none

module url_path_slash_collapse_percent_decode_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  url_psd_in_if.sink       in_ch,
  url_psd_out_if.source    out_ch
);
  import url_psd_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  logic             prev_slash_r, prev_slash_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [ByteW-1:0] held_r, held_nxt;

  res_t             q_r [QDepth];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  cnt_r;

  res_t             res [MaxRes];
  logic [1:0]       n_res;

  logic             acc, pop;
  logic [ByteW-1:0] c;
  hex_t             hc, hh;
  logic             drop;

  assign acc = in_ch.valid & in_ch.ready;
  assign pop = out_ch.valid & out_ch.ready;
  assign c   = in_ch.path_byte;
  assign hc  = hex_decode(c);
  assign hh  = hex_decode(held_r);
  assign drop = (c == ChSlash) && prev_slash_r;

  assign in_ch.ready = (cnt_r <= CntW'(QDepth - MaxRes));

  always_comb begin
    logic pct_c;
    pct_c          = (c == ChPercent);
    prev_slash_nxt = (c == ChSlash);
    phase_nxt      = phase_r;
    held_nxt       = held_r;
    n_res          = 2'd0;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '{out_char: '0, has_char: 1'b0, path_done: 1'b0};
    end

    if (!drop) begin
      unique case (phase_r)
        PhPct: begin
          if (hc.ok) begin
            held_nxt  = c;
            phase_nxt = PhDigit;
          end else begin
            res[n_res] = '{out_char: ChPercent, has_char: 1'b1, path_done: 1'b0};
            n_res      = n_res + 2'd1;
            if (pct_c) begin
              phase_nxt = PhPct;
            end else begin
              phase_nxt  = PhIdle;
              res[n_res] = '{out_char: c, has_char: 1'b1, path_done: 1'b0};
              n_res      = n_res + 2'd1;
            end
          end
        end
        PhDigit: begin
          if (hc.ok) begin
            res[0]    = '{out_char: {hh.val, hc.val}, has_char: 1'b1, path_done: 1'b0};
            n_res     = 2'd1;
            phase_nxt = PhIdle;
            held_nxt  = '0;
          end else begin
            res[0]   = '{out_char: ChPercent, has_char: 1'b1, path_done: 1'b0};
            res[1]   = '{out_char: held_r, has_char: 1'b1, path_done: 1'b0};
            n_res    = 2'd2;
            held_nxt = '0;
            if (pct_c) begin
              phase_nxt = PhPct;
            end else begin
              phase_nxt = PhIdle;
              res[2]    = '{out_char: c, has_char: 1'b1, path_done: 1'b0};
              n_res     = 2'd3;
            end
          end
        end
        default: begin
          if (pct_c) begin
            phase_nxt = PhPct;
          end else begin
            phase_nxt = PhIdle;
            res[0]    = '{out_char: c, has_char: 1'b1, path_done: 1'b0};
            n_res     = 2'd1;
          end
        end
      endcase
    end

    if (in_ch.is_final) begin
      // flush held escape characters
      if (phase_nxt == PhPct) begin
        if (n_res < 2'd3) begin
          res[n_res] = '{out_char: ChPercent, has_char: 1'b1, path_done: 1'b0};
          n_res      = n_res + 2'd1;
        end
      end else if (phase_nxt == PhDigit) begin
        if (n_res < 2'd3) begin
          res[n_res] = '{out_char: ChPercent, has_char: 1'b1, path_done: 1'b0};
          n_res      = n_res + 2'd1;
        end
        if (n_res < 2'd3) begin
          res[n_res] = '{out_char: held_nxt, has_char: 1'b1, path_done: 1'b0};
          n_res      = n_res + 2'd1;
        end
      end
      if (n_res == 2'd0) begin
        res[0] = '{out_char: '0, has_char: 1'b0, path_done: 1'b1};
        n_res  = 2'd1;
      end else begin
        res[n_res - 2'd1].path_done = 1'b1;
      end
      prev_slash_nxt = 1'b0;
      phase_nxt      = PhIdle;
      held_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_slash_r <= 1'b0;
      phase_r      <= PhIdle;
      held_r       <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (acc) begin
        prev_slash_r <= prev_slash_nxt;
        phase_r      <= phase_nxt;
        held_r       <= held_nxt;
        wr_ptr_r     <= wr_ptr_r + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      cnt_r <= cnt_r + (acc ? CntW'(n_res) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (2'(i) < n_res) begin
          q_r[wr_ptr_r + PtrW'(i)] <= res[i];
        end
      end
    end
  end

  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.out_char  = q_r[rd_ptr_r].out_char;
  assign out_ch.has_char  = q_r[rd_ptr_r].has_char;
  assign out_ch.path_done = q_r[rd_ptr_r].path_done;

endmodule

`default_nettype wire
